FILE: design/blhi_pkg.sv
// Shared types, codes and reset values for the battery level hysteresis indicator.
package blhi_pkg;

	localparam int unsigned MV_W    = 13;
	localparam int unsigned DEB_W   = 10;
	localparam int unsigned BLINK_W = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 13;

	localparam logic [1:0] LVL_HIGH = 2'd0;
	localparam logic [1:0] LVL_MID  = 2'd1;
	localparam logic [1:0] LVL_LOW  = 2'd2;

	localparam logic [1:0] ST_NORMAL   = 2'd0;
	localparam logic [1:0] ST_VOLT_ERR = 2'd1;

	localparam logic [1:0] BEEP_NONE = 2'd0;
	localparam logic [1:0] BEEP_WARN = 2'd1;
	localparam logic [1:0] BEEP_STOP = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_TO_MID   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MID_TO_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MID_TO_LOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_TO_MID    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MID_BLINK     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BLINK     = 3'd6;

	localparam logic [MV_W-1:0]    RST_HIGH_TO_MID = 13'd3770;
	localparam logic [MV_W-1:0]    RST_MID_TO_HIGH = 13'd3790;
	localparam logic [MV_W-1:0]    RST_MID_TO_LOW  = 13'd3650;
	localparam logic [MV_W-1:0]    RST_LOW_TO_MID  = 13'd3680;
	localparam logic [DEB_W-1:0]   RST_DEBOUNCE    = 10'd400;
	localparam logic [BLINK_W-1:0] RST_MID_BLINK   = 8'd200;
	localparam logic [BLINK_W-1:0] RST_LOW_BLINK   = 8'd50;

	typedef struct packed {
		logic [MV_W-1:0] voltage_mv;
		logic [1:0]      run_status;
	} item_t;

	typedef struct packed {
		logic [1:0] battery_level;
		logic       power_led_bit;
		logic [1:0] beep_command;
		logic [1:0] new_run_status;
	} result_t;

	typedef struct packed {
		logic [MV_W-1:0]    high_to_mid_mv;
		logic [MV_W-1:0]    mid_to_high_mv;
		logic [MV_W-1:0]    mid_to_low_mv;
		logic [MV_W-1:0]    low_to_mid_mv;
		logic [DEB_W-1:0]   debounce_ticks;
		logic [BLINK_W-1:0] mid_blink_period;
		logic [BLINK_W-1:0] low_blink_period;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         level;
		logic [DEB_W-1:0]   rise_count;
		logic [DEB_W-1:0]   fall_count;
		logic [BLINK_W-1:0] blink_count;
	} state_t;

endpackage

FILE: design/blhi_step.sv
// Next-state and result logic for one voltage tick.
module blhi_step
	import blhi_pkg::*;
(
	input  state_t  cur,
	input  cfg_t    cfg,
	input  item_t   item,
	output state_t  nxt,
	output result_t res
);

	logic               below_h2m, above_m2h, below_m2l, above_l2m;
	logic               rise_done, fall_done;
	logic [DEB_W-1:0]   rise_inc, fall_inc;
	logic [1:0]         lvl_n;
	logic [BLINK_W-1:0] period, blink_n;
	logic [1:0]         st_n, beep;

	assign below_h2m = item.voltage_mv < cfg.high_to_mid_mv;
	assign above_m2h = item.voltage_mv > cfg.mid_to_high_mv;
	assign below_m2l = item.voltage_mv < cfg.mid_to_low_mv;
	assign above_l2m = item.voltage_mv > cfg.low_to_mid_mv;

	// debounce counters: done once the count has reached the limit
	assign rise_done = !(cur.rise_count < cfg.debounce_ticks);
	assign fall_done = !(cur.fall_count < cfg.debounce_ticks);
	assign rise_inc  = rise_done ? '0 : cur.rise_count + DEB_W'(1);
	assign fall_inc  = fall_done ? '0 : cur.fall_count + DEB_W'(1);

	always_comb begin
		lvl_n          = cur.level;
		nxt.rise_count = '0;
		nxt.fall_count = '0;
		if (cur.level == LVL_HIGH) begin
			if (below_h2m) begin
				nxt.fall_count = fall_inc;
				if (fall_done) lvl_n = LVL_MID;
			end
		end else if (cur.level == LVL_MID) begin
			if (above_m2h) begin
				nxt.rise_count = rise_inc;
				if (rise_done) lvl_n = LVL_HIGH;
			end else if (below_m2l) begin
				nxt.fall_count = fall_inc;
				if (fall_done) lvl_n = LVL_LOW;
			end
		end else begin
			if (above_l2m) begin
				nxt.rise_count = rise_inc;
				if (rise_done) lvl_n = LVL_MID;
			end
		end
	end

	always_comb begin
		st_n = item.run_status;
		beep = BEEP_NONE;
		if (lvl_n == LVL_HIGH || lvl_n == LVL_MID) begin
			period = (lvl_n == LVL_HIGH) ? '0 : cfg.mid_blink_period;
			if (item.run_status == ST_VOLT_ERR) begin
				beep = BEEP_STOP;
				st_n = ST_NORMAL;
			end
		end else begin
			period = cfg.low_blink_period;
			if (item.run_status == ST_NORMAL) begin
				beep = BEEP_WARN;
				st_n = ST_VOLT_ERR;
			end
		end
	end

	assign blink_n = (cur.blink_count < period) ? cur.blink_count + BLINK_W'(1) : '0;

	assign nxt.level       = lvl_n;
	assign nxt.blink_count = blink_n;

	assign res.battery_level  = lvl_n;
	assign res.power_led_bit  = blink_n <= (period >> 1);
	assign res.beep_command   = beep;
	assign res.new_run_status = st_n;

endmodule

FILE: design/battery_level_hysteresis_indicator_unit.sv
// Top level of the battery level hysteresis indicator.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------
//  item     | item_valid / item_stall   | item   (voltage_mv, run_status)
//  result   | result_valid/result_stall | result (level, led, beep, status)
//  config   | cfg_we                    | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while the result is not stalled; the path runs
// through the input register then the result register, with the state update in between.
// Reset restores register defaults, high level and cleared counters.
// A stalled result holds the input register; the input stalls only when both are full.
module battery_level_hysteresis_indicator_unit
	import blhi_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	state_t  state_q, state_n;
	logic    valid_s1;
	item_t   item_s1;
	result_t res_n;
	logic    adv;

	assign adv        = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_to_mid_mv   <= RST_HIGH_TO_MID;
			cfg_q.mid_to_high_mv   <= RST_MID_TO_HIGH;
			cfg_q.mid_to_low_mv    <= RST_MID_TO_LOW;
			cfg_q.low_to_mid_mv    <= RST_LOW_TO_MID;
			cfg_q.debounce_ticks   <= RST_DEBOUNCE;
			cfg_q.mid_blink_period <= RST_MID_BLINK;
			cfg_q.low_blink_period <= RST_LOW_BLINK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HIGH_TO_MID: cfg_q.high_to_mid_mv   <= cfg_wdata[MV_W-1:0];
				REG_MID_TO_HIGH: cfg_q.mid_to_high_mv   <= cfg_wdata[MV_W-1:0];
				REG_MID_TO_LOW:  cfg_q.mid_to_low_mv    <= cfg_wdata[MV_W-1:0];
				REG_LOW_TO_MID:  cfg_q.low_to_mid_mv    <= cfg_wdata[MV_W-1:0];
				REG_DEBOUNCE:    cfg_q.debounce_ticks   <= cfg_wdata[DEB_W-1:0];
				REG_MID_BLINK:   cfg_q.mid_blink_period <= cfg_wdata[BLINK_W-1:0];
				REG_LOW_BLINK:   cfg_q.low_blink_period <= cfg_wdata[BLINK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) item_s1 <= item;
	end

	blhi_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_n),
		.res  (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.level       <= LVL_HIGH;
			state_q.rise_count  <= '0;
			state_q.fall_count  <= '0;
			state_q.blink_count <= '0;
			result_valid        <= 1'b0;
		end else if (adv) begin
			state_q      <= state_n;
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) result <= res_n;
	end

`ifndef SYNTHESIS
	a_one_counter: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.rise_count != '0 && state_q.fall_count != '0))
		else $error("rise and fall counters both active");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid && result_stall) |=> valid_s1)
		else $error("input register lost a transaction under stall");

	a_high_led_on: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.battery_level == LVL_HIGH) |-> result.power_led_bit)
		else $error("power LED off at high level");

	a_warn_low: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.beep_command == BEEP_WARN) |->
		(result.battery_level == LVL_LOW && result.new_run_status == ST_VOLT_ERR))
		else $error("warning beep outside low level");
`endif

endmodule
